>>> rtl/core/mcmp_pkg.sv
// shared types and constants for the midi channel message parser
`default_nettype none

package mcmp_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_DATA1 = 2'd1,
      PHASE_DATA2 = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      TYPE_NOTE_OFF  = 4'h8,
      TYPE_NOTE_ON   = 4'h9,
      TYPE_POLY_PRES = 4'hA,
      TYPE_CTRL      = 4'hB,
      TYPE_PROGRAM   = 4'hC,
      TYPE_CHAN_PRES = 4'hD,
      TYPE_BEND      = 4'hE
   } msg_code_type;

   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CHAN_W  = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BEND_W  = 14;
   localparam int unsigned RSP_W   = KIND_W + CHAN_W + 2 * BYTE_W + BEND_W;
   localparam int unsigned RSP_PAD = ((RSP_W + 7) / 8) * 8;

   typedef struct packed {
      logic [KIND_W-1:0]        event_kind;
      logic [CHAN_W-1:0]        channel_number;
      logic [BYTE_W-1:0]        first_value;
      logic [BYTE_W-1:0]        second_value;
      logic signed [BEND_W-1:0] bend_amount;
   } event_type;

endpackage

`default_nettype wire

>>> rtl/core/midi_channel_message_parser.sv
// midi channel voice message parser top level
`default_nettype none

// Takes one MIDI byte per word and emits one word per completed channel voice
// message (note off/on, poly pressure, controller, program, channel pressure,
// pitch bend). A byte is registered on entry, then one pass of small logic
// updates the parse state and loads the result register, so a byte can be
// taken every cycle; a byte stalls only when it completes a message while the
// previous result is still waiting on rsp_tready. Data bytes are not checked
// for bit 7 and there is no running status; bend_amount is the 14-bit value
// minus 0x2000.
module midi_channel_message_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] midi_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [2:0] event_kind, [6:3] channel_number,
                                         // [14:7] first_value, [22:15] second_value,
                                         // [36:23] bend_amount, [39:37] zero
);

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_byte_ff;
   mcmp_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           mtype_ff, mtype_in;
   logic [3:0]           chan_ff, chan_in;
   logic [7:0]           first_ff, first_in;
   logic                 out_vld_ff, out_vld_in;
   mcmp_pkg::event_type  evt_ff, evt_in;

   logic                 emit;
   logic                 advance;
   logic                 is_voice;
   logic [13:0]          bend_raw;

   assign is_voice = (mtype_ff >= mcmp_pkg::TYPE_NOTE_OFF) && (mtype_ff <= mcmp_pkg::TYPE_BEND);
   assign advance  = in_vld_ff && (!emit || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   // next state
   always_comb begin
      phase_in = phase_ff;
      mtype_in = mtype_ff;
      chan_in  = chan_ff;
      first_in = first_ff;
      if (advance) begin
         unique case (phase_ff)
            mcmp_pkg::PHASE_IDLE: begin
               mtype_in = in_byte_ff[7:4];
               chan_in  = in_byte_ff[3:0];
               phase_in = ((in_byte_ff[7:4] >= mcmp_pkg::TYPE_NOTE_OFF) &&
                           (in_byte_ff[7:4] <= mcmp_pkg::TYPE_BEND))
                          ? mcmp_pkg::PHASE_DATA1 : mcmp_pkg::PHASE_IDLE;
            end
            mcmp_pkg::PHASE_DATA1: begin
               first_in = in_byte_ff;
               if ((mtype_ff == mcmp_pkg::TYPE_PROGRAM) ||
                   (mtype_ff == mcmp_pkg::TYPE_CHAN_PRES)) begin
                  phase_in = mcmp_pkg::PHASE_IDLE;
               end else if (is_voice) begin
                  phase_in = mcmp_pkg::PHASE_DATA2;
               end else begin
                  phase_in = mcmp_pkg::PHASE_IDLE;
               end
            end
            default: begin
               phase_in = mcmp_pkg::PHASE_IDLE;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      bend_raw                = {in_byte_ff[6:0], first_ff[6:0]};
      emit                    = 1'b0;
      evt_in.event_kind       = 3'(mtype_ff - mcmp_pkg::TYPE_NOTE_OFF);
      evt_in.channel_number   = chan_ff;
      evt_in.first_value      = first_ff;
      evt_in.second_value     = in_byte_ff;
      evt_in.bend_amount      = '0;
      unique case (phase_ff)
         mcmp_pkg::PHASE_IDLE: begin
            emit = 1'b0;
         end
         mcmp_pkg::PHASE_DATA1: begin
            emit                = (mtype_ff == mcmp_pkg::TYPE_PROGRAM) ||
                                  (mtype_ff == mcmp_pkg::TYPE_CHAN_PRES);
            evt_in.first_value  = in_byte_ff;
            evt_in.second_value = '0;
         end
         mcmp_pkg::PHASE_DATA2: begin
            emit = (mtype_ff == mcmp_pkg::TYPE_BEND) ||
                   ((mtype_ff >= mcmp_pkg::TYPE_NOTE_OFF) &&
                    (mtype_ff <= mcmp_pkg::TYPE_CTRL));
            if (mtype_ff == mcmp_pkg::TYPE_BEND) begin
               evt_in.bend_amount = {~bend_raw[13], bend_raw[12:0]};
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance && emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= mcmp_pkg::PHASE_IDLE;
         mtype_ff   <= '0;
         chan_ff    <= '0;
         first_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         mtype_ff   <= mtype_in;
         chan_ff    <= chan_in;
         first_ff   <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && emit) begin
         evt_ff <= evt_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, evt_ff.bend_amount, evt_ff.second_value,
                        evt_ff.first_value, evt_ff.channel_number, evt_ff.event_kind};

endmodule

`default_nettype wire
